// File: rtl/ipd_pkg.sv
// shared constants and types for the ipd frame deframer
// no dependencies; imported by every module of the block
package ipd_pkg;

  // data ring geometry, one slot is always kept free
  localparam int unsigned RingDepth = 512;
  localparam int unsigned RingIdxW  = $clog2(RingDepth);

  // classified-op queue between parser and ring engine
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 12;
  localparam int unsigned FillW = 9;
  localparam int unsigned DropW = 32;

  localparam logic [LenW-1:0] MaxLenReset = LenW'(2048);

  // what the ring engine does with one item
  typedef enum logic [1:0] {
    OpNone = 2'd0,
    OpPush = 2'd1,
    OpPop  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [ByteW-1:0] data;
    logic             first;  // first payload byte of a frame
    logic             done;   // item completes a frame
  } op_t;

endpackage

// File: rtl/ipd_front.sv
// header parser: hunts for the marker, decodes the length field, classifies items
// depends on ipd_pkg
module ipd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  input  logic                        s_cmd_i,
  input  logic [ipd_pkg::ByteW-1:0]   s_byte_i,
  output logic                        s_ready_o,
  input  logic                        cfg_valid_i,
  input  logic [ipd_pkg::LenW-1:0]    cfg_data_i,
  output logic                        cfg_ready_o,
  output logic                        op_valid_o,
  output ipd_pkg::op_t                op_o,
  input  logic                        op_ready_i
);
  import ipd_pkg::*;

  typedef enum logic [2:0] {
    PhHunt    = 3'b001,
    PhHeader  = 3'b010,
    PhPayload = 3'b100
  } phase_e;

  localparam int unsigned MarkerLen = 5;
  localparam int unsigned MatchW    = 3;
  localparam int unsigned ValW      = LenW + 4;
  localparam logic [ByteW-1:0] Marker [MarkerLen] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  phase_e            phase_q, phase_d;
  logic [MatchW-1:0] match_q, match_d;
  logic [LenW-1:0]   field_q, field_d;
  logic              bad_q, bad_d;
  logic [LenW-1:0]   rem_q, rem_d;
  logic              first_q, first_d;
  logic [LenW-1:0]   max_q;

  logic              accept;
  logic [MatchW-1:0] k;
  logic [3:0]        digit;
  logic [ValW-1:0]   val;
  logic [LenW-1:0]   rem_dec;
  logic              is_digit;

  assign accept      = s_valid_i && op_ready_i;
  assign s_ready_o   = op_ready_i;
  assign op_valid_o  = s_valid_i;
  assign cfg_ready_o = 1'b1;

  assign k        = (match_q >= MatchW'(MarkerLen)) ? '0 : match_q;
  assign is_digit = (s_byte_i >= ChZero) && (s_byte_i <= ChNine);
  assign digit    = 4'(s_byte_i - ChZero);
  // value times ten as shift-and-add
  assign val      = {1'b0, field_q, 3'b000} + {3'b000, field_q, 1'b0}
                  + {{(ValW-4){1'b0}}, digit};
  assign rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    field_d = field_q;
    bad_d   = bad_q;
    rem_d   = rem_q;
    first_d = first_q;
    op_o.kind  = OpNone;
    op_o.data  = s_byte_i;
    op_o.first = first_q;
    op_o.done  = 1'b0;
    if (s_cmd_i) begin
      op_o.kind = OpPop;
    end else begin
      unique case (phase_q)
        PhHunt: begin
          if (s_byte_i == Marker[k]) begin
            if (k == MatchW'(MarkerLen - 1)) begin
              match_d = '0;
              phase_d = PhHeader;
              field_d = '0;
              bad_d   = 1'b0;
            end else begin
              match_d = k + 1'b1;
            end
          end else begin
            match_d = (s_byte_i == ChPlus) ? MatchW'(1) : '0;
          end
        end
        PhHeader: begin
          if (s_byte_i == ChComma) begin
            field_d = '0;
            bad_d   = 1'b0;
          end else if (is_digit) begin
            if (!bad_q) begin
              if (val > {4'b0000, max_q}) bad_d = 1'b1;
              else                          field_d = val[LenW-1:0];
            end
          end else if (s_byte_i == ChColon) begin
            match_d = '0;
            if (bad_q) begin
              phase_d = PhHunt;
            end else if (field_q == '0) begin
              phase_d   = PhHunt;
              op_o.done = 1'b1;
            end else begin
              rem_d   = field_q;
              first_d = 1'b1;
              phase_d = PhPayload;
            end
          end else begin
            bad_d = 1'b1;
          end
        end
        PhPayload: begin
          op_o.kind = OpPush;
          first_d   = 1'b0;
          rem_d     = rem_dec;
          if (rem_dec == '0) begin
            phase_d   = PhHunt;
            match_d   = '0;
            op_o.done = 1'b1;
          end
        end
        default: begin
          phase_d = PhHunt;
          match_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      match_q <= '0;
      field_q <= '0;
      bad_q   <= 1'b0;
      rem_q   <= '0;
      first_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      match_q <= match_d;
      field_q <= field_d;
      bad_q   <= bad_d;
      rem_q   <= rem_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

endmodule

// File: rtl/ipd_queue.sv
// short fifo of classified ops between the parser and the ring engine
// depends on ipd_pkg
module ipd_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  ipd_pkg::op_t push_data_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output ipd_pkg::op_t pop_data_o,
  input  logic         pop_ready_i
);
  import ipd_pkg::*;

  op_t              slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == QPtrW'(QDepth-1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == QPtrW'(QDepth-1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QDepth))
    else $error("queue count above depth");
`endif

endmodule

// File: rtl/ipd_back.sv
// ring engine: data ring memory, drop counter and the registered result
// depends on ipd_pkg
module ipd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  input  ipd_pkg::op_t               op_i,
  output logic                       op_ready_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic                       m_read_valid_o,
  output logic [ipd_pkg::ByteW-1:0]  m_read_byte_o,
  output logic                       m_frame_done_o,
  output logic [ipd_pkg::DropW-1:0]  m_dropped_o,
  output logic [ipd_pkg::FillW-1:0]  m_fill_o
);
  import ipd_pkg::*;

  function automatic logic [RingIdxW-1:0] ring_next(input logic [RingIdxW-1:0] idx);
    return (idx == RingIdxW'(RingDepth-1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [RingIdxW:0] ring_fill(input logic [RingIdxW-1:0] wr,
                                                  input logic [RingIdxW-1:0] rd);
    logic [RingIdxW:0] w, r;
    w = {1'b0, wr};
    r = {1'b0, rd};
    return (w >= r) ? w - r : w + (RingIdxW+1)'(RingDepth) - r;
  endfunction

  logic [ByteW-1:0]    mem [RingDepth];
  logic [ByteW-1:0]    rdata_q;
  logic [RingIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic                skip_q, skip_d;
  logic [DropW-1:0]    drop_q, drop_d;
  logic                out_valid_q, rv_q, done_q;
  logic [FillW-1:0]    fill_q;

  logic adv, empty, full, skip_eff, do_write, do_read;

  assign adv        = op_valid_i && (!out_valid_q || m_ready_i);
  assign op_ready_o = adv;
  assign empty      = (wr_q == rd_q);
  assign full       = (ring_next(wr_q) == rd_q);
  assign skip_eff   = op_i.first ? 1'b0 : skip_q;
  assign do_write   = adv && (op_i.kind == OpPush) && !skip_eff && !full;
  assign do_read    = adv && (op_i.kind == OpPop) && !empty;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    skip_d = skip_q;
    drop_d = drop_q;
    case (op_i.kind)
      OpPush: begin
        skip_d = skip_eff;
        if (!skip_eff) begin
          if (full) begin
            drop_d = drop_q + 1'b1;
            skip_d = 1'b1;
          end else begin
            wr_d = ring_next(wr_q);
          end
        end
      end
      OpPop: begin
        if (!empty) rd_d = ring_next(rd_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_write) mem[wr_q] <= op_i.data;
    if (do_read)  rdata_q   <= mem[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      skip_q      <= 1'b0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      done_q      <= 1'b0;
      fill_q      <= '0;
    end else if (adv) begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      skip_q      <= skip_d;
      drop_q      <= drop_d;
      out_valid_q <= 1'b1;
      rv_q        <= do_read;
      done_q      <= op_i.done;
      fill_q      <= FillW'(ring_fill(wr_d, rd_d));
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_valid_o      = out_valid_q;
  assign m_read_valid_o = rv_q;
  assign m_read_byte_o  = rv_q ? rdata_q : '0;
  assign m_frame_done_o = done_q;
  assign m_dropped_o    = drop_q;
  assign m_fill_o       = fill_q;

`ifndef SYNTHESIS
  a_fill_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fill_q == FillW'(ring_fill(wr_q, rd_q))))
    else $error("reported fill does not match ring pointers");

  a_drop_only_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (op_i.kind != OpPush)) |=> $stable(drop_q))
    else $error("drop counter moved without a payload byte");

  a_read_valid_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (rv_q == $past((op_i.kind == OpPop) && (wr_q != rd_q))))
    else $error("read flag disagrees with pop on a nonempty ring");
`endif

endmodule

// File: rtl/ipd_frame_deframer_top.sv
// top level of the ipd frame deframer: stream ports, parser, op queue, ring engine
// depends on ipd_pkg, ipd_front, ipd_queue, ipd_back
//
// The block takes one item per clock: either a byte received from the modem
// link (tuser cmd 0) or a pop of one payload byte from the data ring (cmd 1).
// Every item gives exactly one result, in order. The parser hunts for the
// "+IPD," marker, decodes the decimal length after the last comma before the
// colon and pushes the following payload bytes into a 512-entry ring that
// holds up to 511 bytes. A result carries the popped byte with its flag, the
// frame-done mark on tlast, the drop counter and the ring fill after the item.
// Sustained rate is one item per cycle while the output is not stalled; an
// accepted item is first written into the op queue, then goes through the
// ring access into the output register. The ring is single-write with a
// registered read. The ring needs no clearing pass after reset: only entries
// written since reset are ever read.
module ipd_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] read_byte, [39:8] dropped_frames,
                                      // [48:40] fill_level, [55:49] zero
  output logic [0:0]  m_axis_tuser,   // [0] read_valid
  output logic        m_axis_tlast,   // frame_done
  // max payload length register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);
  import ipd_pkg::*;

  // front to queue
  logic f_valid, f_ready;
  op_t  f_op;
  // queue to back
  logic b_valid, b_ready;
  op_t  b_op;

  logic [ByteW-1:0] rd_byte;
  logic [DropW-1:0] dropped;
  logic [FillW-1:0] fill;

  // parser classifies each item and keeps the header state
  ipd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_cmd_i     (s_axis_tuser[0]),
    .s_byte_i    (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .op_valid_o  (f_valid),
    .op_o        (f_op),
    .op_ready_i  (f_ready)
  );

  // decouples parser from output backpressure
  ipd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_data_i  (f_op),
    .push_ready_o (f_ready),
    .pop_valid_o  (b_valid),
    .pop_data_o   (b_op),
    .pop_ready_i  (b_ready)
  );

  // ring access, drop counting, result register
  ipd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (b_valid),
    .op_i           (b_op),
    .op_ready_o     (b_ready),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_read_valid_o (m_axis_tuser[0]),
    .m_read_byte_o  (rd_byte),
    .m_frame_done_o (m_axis_tlast),
    .m_dropped_o    (dropped),
    .m_fill_o       (fill)
  );

  // pack result fields, lowest field first, pad to whole bytes
  assign m_axis_tdata = {7'b0000000, fill, dropped, rd_byte};

endmodule
